FILE: hdl/clsr_pkg.sv
`default_nettype none

package clsr_pkg;

	// Field widths of the input and output transfers
	localparam int unsigned OPCODE_W = 2;
	localparam int unsigned ROW_W    = 1;
	localparam int unsigned COLUMN_W = 4;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned BYTE_W   = 8;

	// Geometry defaults and limits
	localparam int unsigned CLSR_ROWS    = 2;
	localparam int unsigned CLSR_COLUMNS = 16;
	localparam int unsigned SCAN_ROW_W   = 2;   // holds row index up to 3

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_REFRESH = 2'd2;

	// HD44780-style set-DDRAM-address command
	localparam logic [BYTE_W-1:0] DDRAM_BASE = 8'h80;

endpackage

`default_nettype wire

FILE: hdl/clsr_in_if.sv
`default_nettype none

interface clsr_in_if
	import clsr_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ROW_W-1:0]    row;
	logic [COLUMN_W-1:0] column;
	logic [CHAR_W-1:0]   character;

	modport source (output valid, opcode, row, column, character, input ready);
	modport sink   (input valid, opcode, row, column, character, output ready);
endinterface

`default_nettype wire

FILE: hdl/clsr_out_if.sv
`default_nettype none

interface clsr_out_if
	import clsr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              is_data;
	logic [BYTE_W-1:0] lcd_byte;
	logic              last;

	modport source (output valid, is_data, lcd_byte, last, input ready);
	modport sink   (input valid, is_data, lcd_byte, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/char_lcd_shadow_refresh_top.sv
// Write cell / clear row: one transfer per cycle while idle (not refreshing),
// done in the cycle it is taken. Refresh: each cell is read and compared; a
// changed cell sends the held data byte of the previous change, if any, then
// its own set-address command; if any cell changed, a final data byte marked
// last closes the pass. Output stalls hold the scan.
// Reset (arst_n low, asynchronous) clears the per-cell valid bits, so both stores
// read as zero at once; no clearing pass.
`default_nettype none

module char_lcd_shadow_refresh_top
	import clsr_pkg::*;
#(
	parameter int unsigned ROWS    = CLSR_ROWS,
	parameter int unsigned COLUMNS = CLSR_COLUMNS
) (
	input  wire         clk,
	input  wire         arst_n,
	clsr_in_if.sink     item,
	clsr_out_if.source  pair
);

	localparam int unsigned CELLS = ROWS * COLUMNS;
	localparam int unsigned IDX_W = $clog2(CELLS);
	localparam int unsigned COL_W = $clog2(COLUMNS);

	typedef enum logic [2:0] {
		S_IDLE,   // accepting transfers
		S_READ,   // issue memory read of current cell
		S_CMP,    // compare frame vs shadow
		S_PDATA,  // send held data byte of previous changed cell
		S_CMD,    // send set-address command of current cell
		S_FLUSH   // send final data byte (if any), marked last
	} state_t;

	state_t state_q;

	// Cell memories: frame store and panel shadow, each with per-cell valid bits
	logic [CHAR_W-1:0] screen_mem [CELLS];
	logic [CHAR_W-1:0] shown_mem  [CELLS];
	logic [CELLS-1:0]  screen_vld_q;
	logic [CELLS-1:0]  shown_vld_q;
	logic [CHAR_W-1:0] screen_rd_q;
	logic [CHAR_W-1:0] shown_rd_q;

	// Scan position
	logic [IDX_W-1:0]      idx_q;
	logic [SCAN_ROW_W-1:0] row_q;
	logic [COL_W-1:0]      col_q;

	// Held bytes: pending data byte of the previous change, current change
	logic              pend_q;
	logic [CHAR_W-1:0] pend_ch_q;
	logic [CHAR_W-1:0] cur_ch_q;
	logic [BYTE_W-1:0] addr_q;

	// Output register
	logic              out_vld_q;
	logic              out_is_data_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              acc;
	logic              wr_ok;
	logic [IDX_W-1:0]  wr_idx;
	logic [CHAR_W-1:0] scr_val;
	logic [CHAR_W-1:0] shw_val;
	logic              cell_diff;
	logic              last_cell;
	logic              can_load;
	logic              load_out;
	logic [BYTE_W-1:0] cell_addr;

	assign item.ready = (state_q == S_IDLE);
	assign acc        = item.valid && item.ready;

	assign wr_ok  = (int'(item.row) < ROWS) && (int'(item.column) < COLUMNS);
	assign wr_idx = IDX_W'(int'(item.row) * COLUMNS + int'(item.column));

	// Invalid entries read as zero
	assign scr_val   = screen_vld_q[idx_q] ? screen_rd_q : '0;
	assign shw_val   = shown_vld_q[idx_q]  ? shown_rd_q  : '0;
	assign cell_diff = (scr_val != shw_val);

	assign last_cell = (row_q == SCAN_ROW_W'(ROWS - 1)) && (col_q == COL_W'(COLUMNS - 1));
	assign can_load  = !out_vld_q || pair.ready;

	// Output register takes a new byte pair this cycle
	assign load_out = can_load && ((state_q == S_PDATA) || (state_q == S_CMD) ||
		(state_q == S_FLUSH && pend_q));

	// 0x80 + 0x40*row + column, wrapping mod 256
	assign cell_addr = BYTE_W'(DDRAM_BASE + {row_q, 6'd0} + BYTE_W'(col_q));

	assign pair.valid    = out_vld_q;
	assign pair.is_data  = out_is_data_q;
	assign pair.lcd_byte = out_byte_q;
	assign pair.last     = out_last_q;

	// Memory ports: synchronous write, registered read
	always_ff @(posedge clk) begin
		if (acc && item.opcode == OP_WRITE && wr_ok) begin
			screen_mem[wr_idx] <= item.character;
		end
		if (state_q == S_CMP && cell_diff) begin
			shown_mem[idx_q] <= scr_val;
		end
		screen_rd_q <= screen_mem[idx_q];
		shown_rd_q  <= shown_mem[idx_q];
	end

	// Valid bits: write marks a frame cell, clear drops a whole frame row back to zero, a changed cell marks the shadow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_vld_q <= '0;
			shown_vld_q  <= '0;
		end else begin
			if (acc && item.opcode == OP_WRITE && wr_ok) begin
				screen_vld_q[wr_idx] <= 1'b1;
			end
			if (acc && item.opcode == OP_CLEAR) begin
				for (int i = 0; i < CELLS; i++) begin
					if (i / COLUMNS == int'(item.row)) begin
						screen_vld_q[i] <= 1'b0;
					end
				end
			end
			if (state_q == S_CMP && cell_diff) begin
				shown_vld_q[idx_q] <= 1'b1;
			end
		end
	end

	// Scan sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			row_q         <= '0;
			col_q         <= '0;
			pend_q        <= 1'b0;
			pend_ch_q     <= '0;
			cur_ch_q      <= '0;
			addr_q        <= '0;
			out_vld_q     <= 1'b0;
			out_is_data_q <= 1'b0;
			out_byte_q    <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (pair.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc && item.opcode == OP_REFRESH) begin
						idx_q   <= '0;
						row_q   <= '0;
						col_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cell_diff) begin
						cur_ch_q <= scr_val;
						addr_q   <= cell_addr;
						state_q  <= pend_q ? S_PDATA : S_CMD;
					end else if (last_cell) begin
						state_q <= S_FLUSH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						if (col_q == COL_W'(COLUMNS - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= S_READ;
					end
				end
				S_PDATA: begin
					if (can_load) begin
						out_is_data_q <= 1'b1;
						out_byte_q    <= pend_ch_q;
						out_last_q    <= 1'b0;
						state_q       <= S_CMD;
					end
				end
				S_CMD: begin
					if (can_load) begin
						out_is_data_q <= 1'b0;
						out_byte_q    <= addr_q;
						out_last_q    <= 1'b0;
						pend_q        <= 1'b1;
						pend_ch_q     <= cur_ch_q;
						if (last_cell) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
							if (col_q == COL_W'(COLUMNS - 1)) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
							state_q <= S_READ;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_q) begin
						state_q <= S_IDLE;
					end else if (can_load) begin
						out_is_data_q <= 1'b1;
						out_byte_q    <= pend_ch_q;
						out_last_q    <= 1'b1;
						pend_q        <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/clsr_chk.sv
`default_nettype none

module clsr_chk
	import clsr_pkg::*;
(
	input wire                clk,
	input wire                arst_n,
	input wire                item_valid,
	input wire                item_ready,
	input wire [OPCODE_W-1:0] item_opcode,
	input wire                pair_valid,
	input wire                pair_ready,
	input wire                pair_is_data,
	input wire [BYTE_W-1:0]   pair_lcd_byte,
	input wire                pair_last
);

	// Stalled output transfer holds
	a_pair_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_ready |=> pair_valid)
		else $error("output valid dropped while stalled");

	a_pair_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_ready |=>
			$stable(pair_lcd_byte) && $stable(pair_is_data) && $stable(pair_last))
		else $error("output payload changed while stalled");

	// A refresh occupies the block
	a_refresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_opcode == OP_REFRESH |=> !item_ready)
		else $error("input still ready after refresh");

	// Write, clear and unused opcodes leave the input ready for the next transfer
	a_simple_op: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_opcode != OP_REFRESH |=> item_ready)
		else $error("input stalled after a single-cycle op");

	// Only a data byte can close a refresh
	a_last_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_is_data |-> !pair_last)
		else $error("last set on a command byte");

endmodule

bind char_lcd_shadow_refresh_top clsr_chk u_clsr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_opcode   (item.opcode),
	.pair_valid    (pair.valid),
	.pair_ready    (pair.ready),
	.pair_is_data  (pair.is_data),
	.pair_lcd_byte (pair.lcd_byte),
	.pair_last     (pair.last)
);

`default_nettype wire

FILE: test/char_lcd_shadow_refresh_top_test.sv
`timescale 1ns / 100ps

module char_lcd_shadow_refresh_top_test;
	import clsr_pkg::*;

	// Opcode 3 has no meaning; the block must drop it.
	localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;
	// DDRAM line stride of the panel: line 1 starts at 0x40.
	localparam logic [BYTE_W-1:0] LINE_STRIDE = 8'h40;

	localparam int CELLS        = CLSR_ROWS * CLSR_COLUMNS;
	localparam int CMD_TARGET   = 170;   // non-ignored commands to generate
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 300;   // quiet time after the last pair

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [ROW_W-1:0]    row;
		logic [COLUMN_W-1:0] column;
		logic [CHAR_W-1:0]   character;
	} lcd_cmd_t;

	typedef struct packed {
		logic              is_data;
		logic [BYTE_W-1:0] lcd_byte;
		logic              last;
	} lcd_pair_t;

	typedef enum logic [1:0] {
		FLOW,
		MOSTLY_READY,
		MOSTLY_STALLED,
		ALTERNATE
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// TB-side copies of the pins the bench drives, so every pin is known from time zero.
	logic     in_valid  = 1'b0;
	lcd_cmd_t in_cmd    = '0;
	logic     out_ready = 1'b0;
	logic     hold_off  = 1'b0;

	clsr_in_if  item_if ();
	clsr_out_if pair_if ();

	assign item_if.valid     = in_valid;
	assign item_if.opcode    = in_cmd.opcode;
	assign item_if.row       = in_cmd.row;
	assign item_if.column    = in_cmd.column;
	assign item_if.character = in_cmd.character;
	assign pair_if.ready     = out_ready;

	char_lcd_shadow_refresh_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if.sink),
		.pair   (pair_if.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	//--------------------------------------------------------------------
	// Predictor: frame store plus panel shadow, scanned on each refresh.
	//--------------------------------------------------------------------
	logic [CHAR_W-1:0] frame_cells [CELLS];
	logic [CHAR_W-1:0] panel_cells [CELLS];

	lcd_cmd_t  cmd_backlog[$];        // commands not yet offered
	lcd_pair_t panel_bytes_due[$];    // byte pairs the panel should still get

	int queued_count = 0;
	int taken_count  = 0;
	int fault_count  = 0;

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			frame_cells[i] = '0;
			panel_cells[i] = '0;
		end
	end

	function automatic void track_command(lcd_cmd_t cmd);
		lcd_pair_t fresh[$];
		lcd_pair_t pair;
		int        idx;
		case (cmd.opcode)
			OP_WRITE: begin
				// Row and column fields cannot exceed the default geometry,
				// but keep the range guard so the model stays honest.
				if (cmd.row < CLSR_ROWS && cmd.column < CLSR_COLUMNS)
					frame_cells[cmd.row * CLSR_COLUMNS + cmd.column] = cmd.character;
			end
			OP_CLEAR: begin
				if (cmd.row < CLSR_ROWS)
					for (int c = 0; c < CLSR_COLUMNS; c++)
						frame_cells[cmd.row * CLSR_COLUMNS + c] = '0;
			end
			OP_REFRESH: begin
				for (int r = 0; r < CLSR_ROWS; r++) begin
					for (int c = 0; c < CLSR_COLUMNS; c++) begin
						idx = r * CLSR_COLUMNS + c;
						if (frame_cells[idx] != panel_cells[idx]) begin
							panel_cells[idx] = frame_cells[idx];
							// set-address command, wraps in 8 bits
							pair.is_data  = 1'b0;
							pair.lcd_byte = DDRAM_BASE + BYTE_W'(r) * LINE_STRIDE
								+ BYTE_W'(c);
							pair.last     = 1'b0;
							fresh.push_back(pair);
							pair.is_data  = 1'b1;
							pair.lcd_byte = frame_cells[idx];
							fresh.push_back(pair);
						end
					end
				end
				// only the data byte of the final changed cell carries last
				if (fresh.size() > 0) begin
					pair = fresh.pop_back();
					pair.last = 1'b1;
					fresh.push_back(pair);
				end
				foreach (fresh[k])
					panel_bytes_due.push_back(fresh[k]);
			end
			default: ;   // unused opcode: no state change, no output
		endcase
	endfunction

	function automatic void add_cmd(logic [OPCODE_W-1:0] op, logic [ROW_W-1:0] row,
			logic [COLUMN_W-1:0] column, logic [CHAR_W-1:0] character);
		lcd_cmd_t cmd;
		cmd.opcode    = op;
		cmd.row       = row;
		cmd.column    = column;
		cmd.character = character;
		cmd_backlog.push_back(cmd);
		queued_count++;
	endfunction

	// Character codes biased toward repeats, so some writes leave a cell unchanged.
	function automatic logic [CHAR_W-1:0] pick_char();
		case ($urandom_range(7, 0))
			0: return 8'h00;
			1: return 8'h20;
			2: return 8'h41;
			default: return CHAR_W'($urandom_range(255, 0));
		endcase
	endfunction

	//--------------------------------------------------------------------
	// Driver: offers commands in bursts with random gaps. The predictor is
	// advanced on every accepted transfer, in acceptance order.
	//--------------------------------------------------------------------
	int       burst_left = 1;
	int       gap_left   = 0;
	lcd_cmd_t next_cmd;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && item_if.ready) begin
				track_command(in_cmd);
				taken_count++;
			end
			if (!in_valid || item_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					next_cmd = cmd_backlog.pop_front();
					in_cmd   <= next_cmd;
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(12, 1);
						// a third of the bursts run straight into the next one
						gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	//--------------------------------------------------------------------
	// Receiver backpressure: a randomly chosen mode, drawn anew when its countdown
	// runs out, plus the long hold-off below.
	//--------------------------------------------------------------------
	stall_mode_t stall_mode = FLOW;
	int          mode_left  = 0;
	logic        take_next;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(3, 0));
				mode_left  = $urandom_range(64, 16);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				FLOW:           take_next = 1'b1;
				MOSTLY_READY:   take_next = ($urandom_range(3, 0) != 0);
				MOSTLY_STALLED: take_next = ($urandom_range(3, 0) == 0);
				default:        take_next = !out_ready;
			endcase
			out_ready <= take_next && !hold_off;
		end
	end

	// Long hold-off once the random traffic is under way: refreshes keep
	// coming, so the block fills up and has to drop item ready.
	initial begin
		wait (taken_count >= 40);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	//--------------------------------------------------------------------
	// Monitor: every pair transfer against the oldest expected pair.
	//--------------------------------------------------------------------
	lcd_pair_t seen_pair;
	lcd_pair_t due_pair;

	always @(posedge clk) begin
		if (arst_n && pair_if.valid && pair_if.ready) begin
			seen_pair.is_data  = pair_if.is_data;
			seen_pair.lcd_byte = pair_if.lcd_byte;
			seen_pair.last     = pair_if.last;
			if (panel_bytes_due.size() == 0) begin
				$display("%0t error: unexpected pair is_data=%0b byte=%02h last=%0b",
					$time, seen_pair.is_data, seen_pair.lcd_byte, seen_pair.last);
				fault_count++;
			end else begin
				due_pair = panel_bytes_due.pop_front();
				if (seen_pair.is_data !== due_pair.is_data) begin
					$display("%0t error: is_data expected %0b got %0b",
						$time, due_pair.is_data, seen_pair.is_data);
					fault_count++;
				end
				if (seen_pair.lcd_byte !== due_pair.lcd_byte) begin
					$display("%0t error: lcd_byte expected %02h got %02h",
						$time, due_pair.lcd_byte, seen_pair.lcd_byte);
					fault_count++;
				end
				if (seen_pair.last !== due_pair.last) begin
					$display("%0t error: last expected %0b got %0b",
						$time, due_pair.last, seen_pair.last);
					fault_count++;
				end
			end
		end
	end

	//--------------------------------------------------------------------
	// Stimulus and end of run.
	//--------------------------------------------------------------------
	int full_fills;
	int cmd_made;
	int n_writes;

	initial begin
		// Directed: empty refresh, byte extremes, corner cells, unused opcode,
		// repeated refresh, same-value rewrite, row clears, write-then-restore.
		add_cmd(OP_REFRESH, 1'b0, 4'd0, 8'h00);     // nothing changed yet
		add_cmd(OP_WRITE,   1'b0, 4'd0, 8'h41);
		add_cmd(OP_WRITE,   1'b1, 4'd15, 8'hFF);
		add_cmd(OP_WRITE,   1'b1, 4'd0, 8'h80);
		add_cmd(OP_WRITE,   1'b0, 4'd15, 8'h7F);
		add_cmd(OP_WRITE,   1'b0, 4'd3, 8'h00);     // equals shadow: no pair
		add_cmd(OP_IGNORED, 1'b1, 4'd9, 8'hAA);     // dropped
		add_cmd(OP_REFRESH, 1'b1, 4'd6, 8'h55);
		add_cmd(OP_REFRESH, 1'b0, 4'd0, 8'h00);     // nothing left to send
		add_cmd(OP_WRITE,   1'b0, 4'd0, 8'h41);     // same value rewritten
		add_cmd(OP_REFRESH, 1'b0, 4'd0, 8'h00);
		add_cmd(OP_CLEAR,   1'b0, 4'd10, 8'hC3);
		add_cmd(OP_REFRESH, 1'b0, 4'd0, 8'h00);     // row 0 cells go back to zero
		add_cmd(OP_CLEAR,   1'b1, 4'd5, 8'h3C);
		add_cmd(OP_WRITE,   1'b1, 4'd15, 8'hFF);    // restored before refresh
		add_cmd(OP_REFRESH, 1'b0, 4'd0, 8'h00);
		add_cmd(OP_WRITE,   1'b0, 4'd5, 8'h55);
		add_cmd(OP_WRITE,   1'b0, 4'd5, 8'h00);     // back to the shown value
		add_cmd(OP_IGNORED, 1'b0, 4'd0, 8'h00);
		add_cmd(OP_REFRESH, 1'b1, 4'd15, 8'hFF);

		// Random: mostly scenes of edits closed by a refresh, a couple of
		// full-screen fills for the longest refresh, sprinkled with noise.
		full_fills = 0;
		cmd_made   = queued_count - 2;   // the two unused opcodes do not count
		while (cmd_made < CMD_TARGET) begin
			if (full_fills < 2 && $urandom_range(9, 0) == 0) begin
				full_fills++;
				for (int i = 0; i < CELLS; i++)
					add_cmd(OP_WRITE, ROW_W'(i / CLSR_COLUMNS), COLUMN_W'(i % CLSR_COLUMNS),
						8'h01 + CHAR_W'($urandom_range(254, 0)));
				add_cmd(OP_REFRESH, ROW_W'($urandom_range(1, 0)),
					COLUMN_W'($urandom_range(15, 0)), CHAR_W'($urandom_range(255, 0)));
				cmd_made += CELLS + 1;
			end else begin
				if ($urandom_range(4, 0) == 0) begin
					add_cmd(OP_CLEAR, ROW_W'($urandom_range(1, 0)),
						COLUMN_W'($urandom_range(15, 0)), CHAR_W'($urandom_range(255, 0)));
					cmd_made++;
				end
				n_writes = $urandom_range(6, 0);
				for (int i = 0; i < n_writes; i++) begin
					add_cmd(OP_WRITE, ROW_W'($urandom_range(1, 0)),
						COLUMN_W'($urandom_range(15, 0)), pick_char());
					cmd_made++;
					if ($urandom_range(9, 0) == 0)
						add_cmd(OP_IGNORED, ROW_W'($urandom_range(1, 0)),
							COLUMN_W'($urandom_range(15, 0)),
							CHAR_W'($urandom_range(255, 0)));
				end
				// occasionally skip the refresh so edits pile up across scenes
				if ($urandom_range(5, 0) != 0) begin
					add_cmd(OP_REFRESH, ROW_W'($urandom_range(1, 0)),
						COLUMN_W'($urandom_range(15, 0)), CHAR_W'($urandom_range(255, 0)));
					cmd_made++;
				end
			end
		end
		add_cmd(OP_REFRESH, 1'b0, 4'd0, 8'h00);     // flush whatever is pending

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (taken_count == queued_count);
		wait (panel_bytes_due.size() == 0);
		// a refresh with nothing changed may still be scanning; catch strays
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/clsr_pkg.sv
hdl/clsr_in_if.sv
hdl/clsr_out_if.sv
hdl/char_lcd_shadow_refresh_top.sv
hdl/clsr_chk.sv
test/char_lcd_shadow_refresh_top_test.sv
